/* design/kli_pkg.sv */
package kli_pkg;

    localparam int KLI_MAX_KEYS        = 64;
    localparam int KLI_ALPHA_FRAC_BITS = 16;
    localparam int KLI_COUNT_W         = 7;
    localparam int KLI_COORDS          = 3;

    localparam logic KLI_OP_WRITE = 1'b0;
    localparam logic KLI_OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FEW_KEYS = 2'd1,
        STATUS_BEFORE   = 2'd2,
        STATUS_AFTER    = 2'd3
    } kli_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_LOW,
        ST_DIV,
        ST_MUL,
        ST_ADD
    } kli_state_t;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         key_index;
        logic [23:0]        key_tick;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [23:0]        query_time;
    } kli_request_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [5:0]         interval_index;
        logic [1:0]         status;
    } kli_result_t;

    typedef struct packed {
        logic [23:0]        key_tick;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
    } kli_entry_t;

endpackage

/* design/keyframe_linear_interpolator.sv */
// channel   direction  handshake                     payload
// request   in         start & !busy                 request (kli_request_t)
// result    out        result_valid, one-cycle pulse result (kli_result_t)
// config    in         cfg_valid & cfg_ready         cfg_data (key_count)
//
// A write request is accepted while idle. A query with fewer than two keys
// answers in the next cycle; otherwise it checks the first and last keys,
// then walks the key table one entry per cycle through the single RAM read
// port, runs a one-bit-per-cycle divider (skipped when alpha is 0 or 1) and
// one shared multiplier for three coordinates. Reset clears the key count
// and control; the table is undefined until written. Results cannot be stalled.
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS        = kli_pkg::KLI_MAX_KEYS,
    parameter int ALPHA_FRAC_BITS = kli_pkg::KLI_ALPHA_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  kli_pkg::kli_request_t                request,
    output logic                                 result_valid,
    output kli_pkg::kli_result_t                 result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kli_pkg::KLI_COUNT_W-1:0]      cfg_data
);
    import kli_pkg::*;

    localparam int AW  = $clog2(MAX_KEYS);
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int EW  = $bits(kli_entry_t);
    localparam int DCW = $clog2(ALPHA_FRAC_BITS + 1);
    localparam int PW  = ALPHA_FRAC_BITS + 35;

    kli_state_t state_reg, state_next;

    logic [KLI_COUNT_W-1:0]     key_count_reg;
    logic                       valid_reg;
    kli_result_t                result_reg;
    logic [23:0]                t_reg;
    logic [AW-1:0]              k_reg;
    logic [23:0]                t2_reg;
    logic signed [31:0]         p2_reg [KLI_COORDS];
    logic signed [31:0]         p1_reg [KLI_COORDS];
    logic signed [32:0]         diff_reg [KLI_COORDS];
    logic signed [31:0]         pos_reg [KLI_COORDS];
    logic [23:0]                rem_reg;
    logic [23:0]                den_reg;
    logic [ALPHA_FRAC_BITS:0]   alpha_reg;
    logic [DCW-1:0]             div_cnt_reg;
    logic [1:0]                 coord_reg;
    logic signed [PW-1:0]       prod_reg;

    logic [CW-1:0]   n_keys;
    logic [CW-1:0]   n_m1;
    logic [CW:0]     k_plus2;
    logic            scan_go;
    logic            accept;
    logic            few_keys;
    logic            ram_we;
    logic [AW-1:0]   widx;
    logic [AW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;
    kli_entry_t      rd;
    kli_entry_t      wentry;
    logic [24:0]     rem_shift;
    logic            rem_ge;
    logic signed [31:0] add_sum;

    always_comb
    begin
        if (32'(key_count_reg) > 32'(MAX_KEYS))
        begin
            n_keys = CW'(MAX_KEYS);
        end
        else
        begin
            n_keys = CW'(key_count_reg);
        end
    end

    assign n_m1     = n_keys - 1'b1;
    assign few_keys = n_keys < CW'(2);
    assign accept   = start && !busy;
    assign rd       = kli_entry_t'(ram_rdata);
    assign k_plus2  = (CW+1)'(k_reg) + (CW+1)'(2);
    assign scan_go  = (k_plus2 < (CW+1)'(n_keys)) && (rd.key_tick < t_reg);

    assign widx   = AW'(request.key_index);
    assign ram_we = accept && (request.opcode == KLI_OP_WRITE)
                    && (32'(request.key_index) < 32'(MAX_KEYS));
    assign wentry = '{key_tick: request.key_tick, key_x: request.key_x,
                      key_y: request.key_y, key_z: request.key_z};

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign add_sum   = p1_reg[coord_reg]
                       + prod_reg[ALPHA_FRAC_BITS+31:ALPHA_FRAC_BITS];

    always_comb
    begin
        ram_raddr = '0;
        case (state_reg)
            ST_FIRST: ram_raddr = n_m1[AW-1:0];
            ST_LAST:  ram_raddr = AW'(1);
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    ram_raddr = k_reg + AW'(2);
                end
                else
                begin
                    ram_raddr = k_reg;
                end
            end
            default:  ram_raddr = '0;
        endcase
    end

    kli_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx),
        .wdata (wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && request.opcode == KLI_OP_QUERY && !few_keys)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                state_next = (t_reg < rd.key_tick) ? ST_IDLE : ST_LAST;
            end
            ST_LAST:
            begin
                state_next = (t_reg > rd.key_tick) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!scan_go)
                begin
                    state_next = ST_LOW;
                end
            end
            ST_LOW:
            begin
                if (t2_reg <= rd.key_tick || t_reg <= rd.key_tick || t_reg >= t2_reg)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DCW'(ALPHA_FRAC_BITS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = (coord_reg == 2'd2) ? ST_IDLE : ST_MUL;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_count_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                key_count_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && request.opcode == KLI_OP_QUERY && few_keys)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                ST_FIRST:
                begin
                    if (t_reg < rd.key_tick)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                ST_LAST:
                begin
                    if (t_reg > rd.key_tick)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                ST_ADD:
                begin
                    if (coord_reg == 2'd2)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                t_reg <= request.query_time;
                if (accept && request.opcode == KLI_OP_QUERY && few_keys)
                begin
                    result_reg <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                                    interval_index: '0, status: STATUS_FEW_KEYS};
                end
            end
            ST_FIRST:
            begin
                if (t_reg < rd.key_tick)
                begin
                    result_reg <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                                    interval_index: '0, status: STATUS_BEFORE};
                end
            end
            ST_LAST:
            begin
                k_reg <= '0;
                if (t_reg > rd.key_tick)
                begin
                    result_reg <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                                    interval_index: '0, status: STATUS_AFTER};
                end
            end
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                else
                begin
                    t2_reg    <= rd.key_tick;
                    p2_reg[0] <= rd.key_x;
                    p2_reg[1] <= rd.key_y;
                    p2_reg[2] <= rd.key_z;
                end
            end
            ST_LOW:
            begin
                p1_reg[0]   <= rd.key_x;
                p1_reg[1]   <= rd.key_y;
                p1_reg[2]   <= rd.key_z;
                diff_reg[0] <= 33'(p2_reg[0]) - 33'(rd.key_x);
                diff_reg[1] <= 33'(p2_reg[1]) - 33'(rd.key_y);
                diff_reg[2] <= 33'(p2_reg[2]) - 33'(rd.key_z);
                rem_reg     <= t_reg - rd.key_tick;
                den_reg     <= t2_reg - rd.key_tick;
                div_cnt_reg <= '0;
                coord_reg   <= '0;
                if (t2_reg <= rd.key_tick || t_reg <= rd.key_tick)
                begin
                    alpha_reg <= '0;
                end
                else if (t_reg >= t2_reg)
                begin
                    alpha_reg <= {1'b1, ALPHA_FRAC_BITS'(0)};
                end
                else
                begin
                    alpha_reg <= '0;
                end
            end
            ST_DIV:
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                alpha_reg   <= {alpha_reg[ALPHA_FRAC_BITS-1:0], rem_ge};
                if (rem_ge)
                begin
                    rem_reg <= 24'(rem_shift - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= rem_shift[23:0];
                end
            end
            ST_MUL:
            begin
                prod_reg <= PW'($signed({1'b0, alpha_reg})) * PW'(diff_reg[coord_reg]);
            end
            ST_ADD:
            begin
                pos_reg[coord_reg] <= add_sum;
                coord_reg          <= coord_reg + 1'b1;
                if (coord_reg == 2'd2)
                begin
                    result_reg <= '{pos_x: pos_reg[0], pos_y: pos_reg[1], pos_z: add_sum,
                                    interval_index: 6'(k_reg), status: STATUS_OK};
                end
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* design/kli_ram.sv */
module kli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* dv/keyframe_linear_interpolator_tb.sv */
`timescale 1ns / 100ps

module keyframe_linear_interpolator_tb;
    import kli_pkg::*;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIME_MAX      = 24'hffffff;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    kli_request_t           request;
    logic                   result_valid;
    kli_result_t            result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [KLI_COUNT_W-1:0] cfg_data;

    kli_entry_t             key_table [KLI_MAX_KEYS];
    logic [KLI_COUNT_W-1:0] key_count;
    kli_result_t            pending_positions [$];
    kli_result_t            expected_pos;

    int cycle_count;
    int error_count;
    int items_sent;
    int key_writes;
    int query_count;
    int count_writes;
    int status_tally [4];
    bit idle_enabled;

    keyframe_linear_interpolator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function automatic int unsigned active_keys();
        return (key_count > KLI_MAX_KEYS) ? KLI_MAX_KEYS : key_count;
    endfunction

    // p1 + floor(alpha * (p2 - p1) / 2^FRAC), difference taken wide
    function automatic logic [31:0] lerp_coord(logic signed [31:0] p1, logic signed [31:0] p2,
                                               int unsigned alpha);
        longint diff;
        longint prod;
        diff = longint'(p2) - longint'(p1);
        prod = longint'(alpha) * diff;
        return 32'(longint'(p1) + (prod >>> KLI_ALPHA_FRAC_BITS));
    endfunction

    function automatic kli_result_t interpolate_position(logic [23:0] when);
        kli_result_t  r;
        int unsigned  n;
        int unsigned  k;
        int unsigned  tq;
        int unsigned  t1;
        int unsigned  t2;
        int unsigned  alpha;
        longint       num;
        r  = '0;
        n  = active_keys();
        tq = when;
        if (n < 2)
            r.status = STATUS_FEW_KEYS;
        else if (tq < key_table[0].key_tick)
            r.status = STATUS_BEFORE;
        else if (tq > key_table[n-1].key_tick)
            r.status = STATUS_AFTER;
        if (r.status != STATUS_OK)
            return r;
        k = 0;
        while (k + 2 < n && key_table[k+1].key_tick < tq)
            k++;
        t1 = key_table[k].key_tick;
        t2 = key_table[k+1].key_tick;
        if (t2 <= t1 || tq <= t1)
            alpha = 0;
        else if (tq >= t2)
            alpha = 1 << KLI_ALPHA_FRAC_BITS;
        else
        begin
            num   = longint'(tq - t1) << KLI_ALPHA_FRAC_BITS;
            alpha = int'(num / longint'(t2 - t1));
        end
        r.pos_x          = lerp_coord(key_table[k].key_x, key_table[k+1].key_x, alpha);
        r.pos_y          = lerp_coord(key_table[k].key_y, key_table[k+1].key_y, alpha);
        r.pos_z          = lerp_coord(key_table[k].key_z, key_table[k+1].key_z, alpha);
        r.interval_index = 6'(k);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_positions.size() == 0)
                report_mismatch("result with nothing pending, status", '0,
                                32'(result.status));
            else
            begin
                expected_pos = pending_positions.pop_front();
                if (result.pos_x !== expected_pos.pos_x)
                    report_mismatch("pos_x", expected_pos.pos_x, result.pos_x);
                if (result.pos_y !== expected_pos.pos_y)
                    report_mismatch("pos_y", expected_pos.pos_y, result.pos_y);
                if (result.pos_z !== expected_pos.pos_z)
                    report_mismatch("pos_z", expected_pos.pos_z, result.pos_z);
                if (result.interval_index !== expected_pos.interval_index)
                    report_mismatch("interval_index", 32'(expected_pos.interval_index),
                                    32'(result.interval_index));
                if (result.status !== expected_pos.status)
                    report_mismatch("status", 32'(expected_pos.status),
                                    32'(result.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_positions.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // start stays high if the next request follows in the same step
    task automatic send_request(input kli_request_t req);
        kli_result_t expect_now;
        while (idle_enabled && $urandom_range(99) < 35)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (req.opcode == KLI_OP_WRITE)
        begin
            key_table[req.key_index] = '{req.key_tick, req.key_x, req.key_y, req.key_z};
            key_writes++;
        end
        else
        begin
            expect_now = interpolate_position(req.query_time);
            pending_positions.push_back(expect_now);
            status_tally[expect_now.status]++;
            query_count++;
        end
    endtask

    task automatic write_key(input int unsigned idx, input int unsigned t,
                             input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        kli_request_t req;
        req.opcode     = KLI_OP_WRITE;
        req.key_index  = 6'(idx);
        req.key_tick   = 24'(t);
        req.key_x      = x;
        req.key_y      = y;
        req.key_z      = z;
        req.query_time = 24'($urandom_range(0, TIME_MAX));
        send_request(req);
    endtask

    task automatic query_at(input int unsigned t);
        kli_request_t req;
        req.opcode     = KLI_OP_QUERY;
        req.key_index  = 6'($urandom_range(0, 63));
        req.key_tick   = 24'($urandom_range(0, TIME_MAX));
        req.key_x      = $urandom;
        req.key_y      = $urandom;
        req.key_z      = $urandom;
        req.query_time = 24'(t);
        send_request(req);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_count(input int unsigned value);
        drain_results();
        while (idle_enabled && $urandom_range(99) < 35)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= KLI_COUNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        key_count = KLI_COUNT_W'(value);
        count_writes++;
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_query_time(int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned r;
        if (n < 2)
            return $urandom_range(0, TIME_MAX);
        lo = key_table[0].key_tick;
        hi = key_table[n-1].key_tick;
        r  = $urandom_range(99);
        if (r < 55 && hi >= lo)
            return $urandom_range(lo, hi);
        if (r < 75)
            return key_table[$urandom_range(0, n-1)].key_tick;
        if (r < 85 && lo > 0)
            return $urandom_range(1) ? lo - 1 : $urandom_range(0, lo - 1);
        if (r < 95 && hi < TIME_MAX)
            return $urandom_range(1) ? hi + 1 : $urandom_range(hi + 1, TIME_MAX);
        return $urandom_range(0, TIME_MAX);
    endfunction

    // with fewer than two keys no table entry is read
    task automatic test_too_few_keys();
        query_at(0);
        query_at(TIME_MAX);
        write_key_count(1);
        query_at($urandom_range(0, TIME_MAX));
    endtask

    task automatic test_key_edges();
        write_key(0, 0, 32'h7fffffff, 32'h80000000, 32'h0);
        write_key(1, TIME_MAX, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        write_key_count(2);
        query_at(0);
        query_at(TIME_MAX);
        query_at(24'h7fffff);
        query_at(1);
        // equal key times, then keys past the last used one
        write_key(0, 100, 32'h00010000, 32'hfffe8000, 32'h7fffffff);
        write_key(1, 100, 32'h00020000, 32'h00000001, 32'h80000000);
        write_key(2, 200, 32'h80000000, 32'h7fffffff, 32'h00000000);
        write_key(3, 24'h800000, 32'h12345678, 32'hedcba987, 32'h00000001);
        write_key_count(1);
        query_at(0);
        write_key_count(4);
        query_at(99);
        query_at(100);
        query_at(150);
        query_at(200);
        query_at(24'h800001);
        // unsorted table
        write_key(1, 50, 32'h7fffffff, 32'h80000000, 32'h00010000);
        write_key_count(3);
        query_at(150);
        query_at(100);
        query_at(201);
    endtask

    task automatic test_full_table();
        int unsigned t;
        t = $urandom_range(0, 255);
        for (int i = 0; i < KLI_MAX_KEYS; i++)
        begin
            if (i == KLI_MAX_KEYS - 1)
                t = TIME_MAX;
            write_key(i, t, rand_coord(), rand_coord(), rand_coord());
            t += $urandom_range(1, 260000);
        end
        write_key_count(KLI_MAX_KEYS);
        query_at(TIME_MAX);
        query_at(key_table[KLI_MAX_KEYS-2].key_tick + 1);
        query_at(key_table[0].key_tick);
        for (int i = 0; i < 3; i++)
            query_at(pick_query_time(KLI_MAX_KEYS));
        write_key_count((1 << KLI_COUNT_W) - 1);
        query_at(TIME_MAX);
        query_at(pick_query_time(KLI_MAX_KEYS));
        write_key_count(KLI_MAX_KEYS + 1);
        query_at(pick_query_time(KLI_MAX_KEYS));
    endtask

    task automatic load_track(input int unsigned n);
        int unsigned shape;
        int unsigned base;
        int unsigned step_max;
        int unsigned cap;
        int unsigned t;
        shape    = $urandom_range(99);
        base     = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 24'h7fffff);
        cap      = (TIME_MAX - base) / ((n == 0) ? 1 : n);
        case ($urandom_range(3))
            0:       step_max = 4;
            1:       step_max = 300;
            2:       step_max = 70000;
            default: step_max = cap;
        endcase
        if (step_max > cap)
            step_max = cap;
        t = base;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && !(shape < 25 && $urandom_range(3) == 0))
                t += $urandom_range(1, step_max);
            write_key(i, (shape < 10) ? $urandom_range(0, TIME_MAX) : t,
                      rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic test_random_tracks();
        int          first_item;
        int unsigned n;
        int unsigned r;
        int unsigned queries;
        int          done;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            done         = items_sent - first_item;
            idle_enabled = (done < 120 || done >= 220);
            r = $urandom_range(99);
            if (r < 65)
                n = $urandom_range(2, 8);
            else if (r < 80)
                n = $urandom_range(9, 24);
            else if (r < 88)
                n = KLI_MAX_KEYS;
            else
                n = $urandom_range(0, 1);
            load_track(n);
            if (n == KLI_MAX_KEYS && $urandom_range(3) == 0)
                write_key_count($urandom_range(KLI_MAX_KEYS, (1 << KLI_COUNT_W) - 1));
            else
                write_key_count(n);
            queries = $urandom_range(3, 12);
            for (int q = 0; q < queries; q++)
            begin
                if ($urandom_range(99) < 15)
                    write_key($urandom_range(0, (n == 0) ? 0 : n - 1), pick_query_time(n),
                              rand_coord(), rand_coord(), rand_coord());
                else
                    query_at(pick_query_time(n));
            end
        end
        idle_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        key_count    = '0;
        idle_enabled = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_too_few_keys();
        test_key_edges();
        test_full_table();
        test_random_tracks();
        drain_results();

        $display("Sent %0d requests: %0d key writes, %0d queries, %0d key_count writes",
                 items_sent, key_writes, query_count, count_writes);
        $display("Query status: ok %0d, too few keys %0d, before first %0d, after last %0d",
                 status_tally[STATUS_OK], status_tally[STATUS_FEW_KEYS],
                 status_tally[STATUS_BEFORE], status_tally[STATUS_AFTER]);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
